// ===== src/ssd_pkg.sv =====
`timescale 1ns / 1ps
package ssd_pkg;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_DRAIN,
    BK_DONE
  } bk_state_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_KERNEL    = 2'd0;
  localparam logic [1:0] REG_DISPARITY = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;
  localparam logic [1:0] REG_HEIGHT    = 2'd3;

  localparam int CENTER_W = 11;
  localparam int DISP_W   = 6;
  localparam int COST_W   = 27;
  localparam int PIX_W    = 8;
  // line store row slot, enough for up to 64 rows
  localparam int SLOT_W   = 6;

  // one window job handed from front to back
  typedef struct packed {
    logic [CENTER_W-1:0] row;
    logic [CENTER_W-1:0] col;
    logic [SLOT_W-1:0]   slot;
  } job_t;

endpackage

// ===== src/ssd_ram.sv =====
`timescale 1ns / 1ps
module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/ssd_front.sv =====
`timescale 1ns / 1ps
module ssd_front #(
  parameter int MAX_KERNEL = 33,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int ROW_W      = 11,
  parameter int POS_W      = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          frame_start,
  input  logic [12:0]                   w_eff,
  input  logic [12:0]                   h_eff,
  input  logic [6:0]                    half2,
  input  logic [8:0]                    nd_eff,
  input  logic [5:0]                    half,
  output logic [ssd_pkg::SLOT_W-1:0]    wr_slot,
  output logic [POS_W-1:0]              wr_col,
  output logic                          job_valid,
  output ssd_pkg::job_t                 job
);
  localparam int SLOT_W = ssd_pkg::SLOT_W;

  logic [POS_W-1:0] row_cnt, col_cnt, row_next, col_next;
  logic [POS_W-1:0] rr, cc;
  logic [POS_W+1:0] need_col, cent_col;
  // store row slot tracks the row counter modulo MAX_KERNEL
  logic [SLOT_W-1:0] slot_cnt, slot_next, ss;

  always_comb begin
    rr = frame_start ? '0 : row_cnt;
    cc = frame_start ? '0 : col_cnt;
    ss = frame_start ? '0 : slot_cnt;
    if ({2'b0, cc} >= {2'b0, w_eff} && POS_W >= 13) begin
      cc = '0;
      rr = rr + 1'b1;
      ss = (ss == SLOT_W'(MAX_KERNEL - 1)) ? '0 : ss + 1'b1;
    end
    if ({2'b0, rr} >= {2'b0, h_eff}) begin
      rr = '0;
      ss = '0;
    end
    need_col = {2'b0, 6'b0, half2} + {6'b0, nd_eff} - 1'b1;
    cent_col = {2'b0, cc} - {9'b0, half} - {6'b0, nd_eff} + 1'b1;
    job_valid = ({2'b0, rr} >= {2'b0, 6'b0, half2})
              && ({2'b0, cc} >= need_col)
              && ({2'b0, cc} + 2'd2 <= {2'b0, w_eff});
    job.row = ROW_W'(rr - POS_W'(half));
    job.col = ROW_W'(cent_col);
    // slot of the top window row, wrapping below slot zero
    if ({1'b0, ss} >= half2) begin
      job.slot = SLOT_W'({1'b0, ss} - half2);
    end else begin
      job.slot = SLOT_W'({1'b0, ss} + 7'(MAX_KERNEL) - half2);
    end
    col_next = cc + 1'b1;
    row_next = rr;
    slot_next = ss;
    if ({2'b0, col_next} >= {2'b0, w_eff}) begin
      col_next = '0;
      row_next = rr + 1'b1;
      slot_next = (ss == SLOT_W'(MAX_KERNEL - 1)) ? '0 : ss + 1'b1;
      if ({2'b0, row_next} >= {2'b0, h_eff}) begin
        row_next = '0;
        slot_next = '0;
      end
    end
  end

  assign wr_slot = ss;
  assign wr_col  = cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      slot_cnt <= '0;
    end else if (accept) begin
      row_cnt  <= row_next;
      col_cnt  <= col_next;
      slot_cnt <= slot_next;
    end
  end
endmodule

// ===== src/ssd_back.sv =====
`timescale 1ns / 1ps
module ssd_back #(
  parameter int MAX_KERNEL = 33,
  parameter int MAX_WIDTH  = 2048,
  parameter int ADDR_W     = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  input  ssd_pkg::job_t                  job,
  output logic                           job_ready,
  input  logic [5:0]                     half,
  input  logic [8:0]                     nd_eff,
  output logic [ADDR_W-1:0]              raddr_l,
  output logic [ADDR_W-1:0]              raddr_r,
  input  logic [ssd_pkg::PIX_W-1:0]      rdata_l,
  input  logic [ssd_pkg::PIX_W-1:0]      rdata_r,
  output logic                           rd_busy,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [ssd_pkg::CENTER_W-1:0]   res_row,
  output logic [ssd_pkg::CENTER_W-1:0]   res_col,
  output logic [ssd_pkg::DISP_W-1:0]     res_disp,
  output logic [ssd_pkg::COST_W-1:0]     res_cost
);
  localparam int SLOT_W = ssd_pkg::SLOT_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);

  ssd_pkg::bk_state_t state, state_next;
  ssd_pkg::job_t cur;
  logic [8:0] d_idx;
  logic [6:0] u_idx, v_idx;
  logic [6:0] span;
  logic       last_uv, last_d;
  logic       p1_valid, p1_last_uv, p1_last_d;
  logic       p2_valid, p2_last_uv, p2_last_d;
  logic       p3_valid, p3_last_uv, p3_last_d;
  logic [8:0] p1_d, p2_d;
  logic [7:0] adiff;
  logic [15:0] sq;
  logic [31:0] acc;
  logic [31:0] best;
  logic [8:0]  best_d;
  logic        have;
  logic [SLOT_W-1:0] slot;
  logic [12:0] x;
  logic [13:0] xr;
  logic        issue;

  assign span = {half, 1'b0};
  assign last_uv = (u_idx == span) && (v_idx == span);
  assign last_d  = (d_idx == nd_eff - 1'b1);
  assign issue   = (state == ssd_pkg::BK_FETCH);

  always_comb begin
    x = {2'b0, cur.col} - {7'b0, half} + {6'b0, u_idx};
    xr = {1'b0, x} + {5'b0, d_idx};
    raddr_l = ADDR_W'({slot, x[COL_W-1:0]});
    raddr_r = ADDR_W'({slot, xr[COL_W-1:0]});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssd_pkg::BK_IDLE:  if (job_valid) state_next = ssd_pkg::BK_FETCH;
      ssd_pkg::BK_FETCH: if (last_uv && last_d) state_next = ssd_pkg::BK_DRAIN;
      ssd_pkg::BK_DRAIN: if (p3_valid && p3_last_uv && p3_last_d)
                           state_next = ssd_pkg::BK_DONE;
      ssd_pkg::BK_DONE:  if (!res_valid || res_ready) state_next = ssd_pkg::BK_IDLE;
      default:           state_next = ssd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == ssd_pkg::BK_IDLE);
    rd_busy   = (state != ssd_pkg::BK_IDLE);
  end

  assign adiff = (rdata_l >= rdata_r) ? rdata_l - rdata_r : rdata_r - rdata_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssd_pkg::BK_IDLE;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      p1_valid <= issue;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (state == ssd_pkg::BK_DONE && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ssd_pkg::BK_IDLE) begin
      cur <= job;
      slot <= job.slot;
      u_idx <= '0;
      v_idx <= '0;
      d_idx <= '0;
      have <= 1'b0;
      acc <= '0;
    end else if (issue) begin
      if (u_idx == span) begin
        u_idx <= '0;
        if (v_idx == span) begin
          v_idx <= '0;
          d_idx <= d_idx + 1'b1;
          slot  <= cur.slot;
        end else begin
          v_idx <= v_idx + 1'b1;
          slot  <= (slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot + 1'b1;
        end
      end else begin
        u_idx <= u_idx + 1'b1;
      end
    end
    // read data arrives in the cycle after its address
    p1_last_uv <= last_uv;
    p1_last_d  <= last_d;
    p1_d       <= d_idx;
    p2_last_uv <= p1_last_uv;
    p2_last_d  <= p1_last_d;
    p2_d       <= p1_d;
    sq         <= 16'(adiff) * 16'(adiff);
    p3_last_uv <= p2_last_uv;
    p3_last_d  <= p2_last_d;
    // square of the sample is in sq while its flags sit in the second stage
    if (p2_valid) begin
      if (p2_last_uv) begin
        acc <= '0;
        if (!have || (acc + {16'b0, sq}) < best) begin
          best   <= acc + {16'b0, sq};
          best_d <= p2_d;
          have   <= 1'b1;
        end
      end else begin
        acc <= acc + {16'b0, sq};
      end
    end
    if (state == ssd_pkg::BK_DONE && (!res_valid || res_ready)) begin
      res_row  <= cur.row;
      res_col  <= cur.col;
      res_disp <= ssd_pkg::DISP_W'(best_d);
      res_cost <= ssd_pkg::COST_W'(best);
    end
  end

  // pipeline guard: no sample should be summed outside a window job
  a_p3_busy: assert property (@(posedge clk) disable iff (rst)
    p3_valid |-> (state == ssd_pkg::BK_DRAIN || state == ssd_pkg::BK_FETCH))
    else $error("sum stage active while idle");
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ssd_pkg::BK_FETCH) |=> $stable(cur))
    else $error("job changed mid window");
  a_done: assert property (@(posedge clk) disable iff (rst)
    (state == ssd_pkg::BK_DONE && !res_valid) |=> res_valid)
    else $error("result not posted");
endmodule

// ===== src/ssd_block_matching_disparity_core.sv =====
`timescale 1ns / 1ps
// ssd block matching disparity core
// input channel: valid/ready carrying left_pixel, right_pixel, frame_start in
// raster order; each item is written into the left and right line stores
// (MAX_KERNEL rows deep) and may complete one window center
// output channel: valid/ready carrying center_row, center_column,
// best_disparity and best_cost for each complete center
// configuration: apb-style port, kernel_size at 0x0, disparity_range at 0x4,
// image_width at 0x8, image_height at 0xc; write only while idle
// flow: items are taken while the hand-off register is empty and the back end
// is not reading the line stores; once an item completes a center, further
// inputs stall until the back end is free; it works through the window for
// each disparity in turn, set by the single read port pair of the line stores
// feeding one squared-difference unit
// reset: counters to row 0 column 0, registers to 3/30/640/480; stores are not
// cleared
// when the receiver stalls, the finished result waits in the output register;
// the back end may finish one more center, then holds it and further inputs stall
module ssd_block_matching_disparity_core #(
  parameter int MAX_KERNEL    = 33,
  parameter int MAX_DISPARITY = 64,
  parameter int MAX_WIDTH     = 2048,
  parameter int MAX_HEIGHT    = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  left_pixel,
  input  logic [7:0]  right_pixel,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] center_row,
  output logic [10:0] center_column,
  output logic [5:0]  best_disparity,
  output logic [26:0] best_cost,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int SLOT_W = ssd_pkg::SLOT_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ADDR_W = SLOT_W + COL_W;
  localparam int DEPTH  = (1 << SLOT_W) * MAX_WIDTH;
  localparam int HMAX   = (MAX_KERNEL - 1) / 2;

  logic [5:0]  kernel_size;
  logic [6:0]  disparity_range;
  logic [11:0] image_width, image_height;
  logic [12:0] w_eff, h_eff;
  logic [8:0]  nd_eff;
  logic [5:0]  half;
  logic [6:0]  half2;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size     <= 6'd3;
      disparity_range <= 7'd30;
      image_width     <= 12'd640;
      image_height    <= 12'd480;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        ssd_pkg::REG_KERNEL:    kernel_size     <= pwdata[5:0];
        ssd_pkg::REG_DISPARITY: disparity_range <= pwdata[6:0];
        ssd_pkg::REG_WIDTH:     image_width     <= pwdata[11:0];
        ssd_pkg::REG_HEIGHT:    image_height    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ssd_pkg::REG_KERNEL:    prdata = {26'b0, kernel_size};
      ssd_pkg::REG_DISPARITY: prdata = {25'b0, disparity_range};
      ssd_pkg::REG_WIDTH:     prdata = {20'b0, image_width};
      ssd_pkg::REG_HEIGHT:    prdata = {20'b0, image_height};
      default:                prdata = '0;
    endcase
  end

  // clamp registers into the supported range
  always_comb begin
    half  = {1'b0, kernel_size[5:1]};
    if (half > 6'(HMAX)) half = 6'(HMAX);
    half2 = {half, 1'b0};
    nd_eff = (disparity_range == 0) ? 9'd1 : {2'b0, disparity_range};
    if (nd_eff > 9'(MAX_DISPARITY)) nd_eff = 9'(MAX_DISPARITY);
    w_eff = (image_width == 0) ? 13'd1 : {1'b0, image_width};
    if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    h_eff = (image_height == 0) ? 13'd1 : {1'b0, image_height};
    if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
  end

  // front end
  logic [12:0]       wr_col;
  logic [SLOT_W-1:0] wr_slot;
  logic              f_job;
  ssd_pkg::job_t     f_jobd;
  logic              in_accept;

  ssd_front #(.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
              .ROW_W(11), .POS_W(13))
    u_front (
      .clk(clk), .rst(rst), .accept(in_accept), .frame_start(frame_start),
      .w_eff(w_eff), .h_eff(h_eff), .half2(half2), .nd_eff(nd_eff), .half(half),
      .wr_slot(wr_slot), .wr_col(wr_col), .job_valid(f_job), .job(f_jobd));

  // one-entry job queue; stores are written only while the back end is not
  // reading, so a window never sees pixels of a later item
  logic          q_valid;
  ssd_pkg::job_t q_job;
  logic          b_ready, rd_busy;

  assign ready     = !q_valid && !rd_busy;
  assign in_accept = valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      if (q_valid && b_ready) q_valid <= 1'b0;
      if (in_accept && f_job) q_valid <= 1'b1;
    end
    if (in_accept && f_job) q_job <= f_jobd;
  end

  // line stores; each memory has its own write and read address ports
  logic [ADDR_W-1:0] waddr, raddr_l, raddr_r;
  logic [7:0]        rdata_l, rdata_r;
  logic [SLOT_W-1:0] wslot;

  assign wslot = wr_slot;
  assign waddr = {wslot, wr_col[COL_W-1:0]};

  ssd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_left (
    .clk(clk), .we(in_accept), .waddr(waddr), .wdata(left_pixel),
    .raddr(raddr_l), .rdata(rdata_l));
  ssd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_right (
    .clk(clk), .we(in_accept), .waddr(waddr), .wdata(right_pixel),
    .raddr(raddr_r), .rdata(rdata_r));

  // back end: window sums per disparity and running minimum
  ssd_back #(.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH), .ADDR_W(ADDR_W))
    u_back (
      .clk(clk), .rst(rst), .job_valid(q_valid), .job(q_job), .job_ready(b_ready),
      .half(half), .nd_eff(nd_eff), .raddr_l(raddr_l), .raddr_r(raddr_r),
      .rdata_l(rdata_l), .rdata_r(rdata_r), .rd_busy(rd_busy),
      .res_valid(out_valid), .res_ready(out_ready), .res_row(center_row),
      .res_col(center_column), .res_disp(best_disparity), .res_cost(best_cost));

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rd_busy |-> !in_accept)
    else $error("store written during window read");
  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !b_ready) |=> q_valid)
    else $error("queued job lost");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> !in_accept)
    else $error("input taken with full queue");
endmodule
